[rtl/bsis_pkg.sv]
// ---------------------------------------------------------------------------
// bsis_pkg: shared types and constants for the binomial series unit
// widths of the fixed-point datapath and the word handed from cell to cell
// ---------------------------------------------------------------------------
package bsis_pkg;

  localparam int MAX_TERMS = 16;
  localparam int FRAC_BITS = 16;

  // field widths
  localparam int X_W   = FRAC_BITS + 1;
  localparam int OUT_W = FRAC_BITS + 4;
  localparam int CNT_W = 5;
  localparam logic [CNT_W-1:0] TERM_RESET = CNT_W'(8);

  // datapath widths
  localparam int MAG_W   = FRAC_BITS + 1;
  localparam int PROD_W  = 2 * MAG_W;
  localparam int K_W     = $clog2(MAX_TERMS);
  localparam int D_W     = K_W + 1;
  localparam int N_W     = $clog2(MAX_TERMS + 1);
  localparam int NUM_W   = MAG_W + D_W + 1;
  localparam int QPROD_W = 2 * NUM_W;
  localparam int SUM_W   = FRAC_BITS + N_W + 2;

  typedef struct packed {
    logic                    valid;
    logic [MAG_W-1:0]        a;
    logic [MAG_W-1:0]        m;
    logic                    neg;
    logic signed [SUM_W-1:0] sum;
    logic [N_W-1:0]          n;
  } cell_data_t;

endpackage

[rtl/bsis_ifs.sv]
// ---------------------------------------------------------------------------
// bsis channel interfaces
// valid/ready channels for the argument and for the series result
// ---------------------------------------------------------------------------
interface bsis_in_if;
  logic                           valid;
  logic                           ready;
  logic signed [bsis_pkg::X_W-1:0] x_value;

  modport source (output valid, output x_value, input ready);
  modport sink (input valid, input x_value, output ready);
endinterface

interface bsis_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [bsis_pkg::OUT_W-1:0] series_value;
  logic                             saturated;

  modport source (output valid, output series_value, output saturated, input ready);
  modport sink (input valid, input series_value, input saturated, output ready);
endinterface

[rtl/bsis_cell.sv]
// ---------------------------------------------------------------------------
// bsis_cell: one series term
// four stages: a*m, round and scale by (2k-1), reciprocal multiply,
// quotient correction and accumulate
// ---------------------------------------------------------------------------
module bsis_cell (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic [bsis_pkg::K_W-1:0]        k_index,
  input  logic [bsis_pkg::NUM_W-1:0]      recip,
  input  bsis_pkg::cell_data_t            up,
  output bsis_pkg::cell_data_t            down
);

  localparam int MAG_W   = bsis_pkg::MAG_W;
  localparam int PROD_W  = bsis_pkg::PROD_W;
  localparam int NUM_W   = bsis_pkg::NUM_W;
  localparam int QPROD_W = bsis_pkg::QPROD_W;
  localparam int SUM_W   = bsis_pkg::SUM_W;
  localparam int N_W     = bsis_pkg::N_W;
  localparam int D_W     = bsis_pkg::D_W;
  localparam int F       = bsis_pkg::FRAC_BITS;

  // carried fields per stage
  logic                    s1_valid, s2_valid, s3_valid;
  logic [MAG_W-1:0]        s1_m, s2_m, s3_m;
  logic                    s1_neg, s2_neg, s3_neg;
  logic signed [SUM_W-1:0] s1_sum, s2_sum, s3_sum;
  logic [N_W-1:0]          s1_n, s2_n, s3_n;

  logic [PROD_W-1:0]  s1_prod;
  logic [NUM_W-1:0]   s2_num;
  logic [NUM_W-1:0]   s3_num;
  logic [QPROD_W-1:0] s3_qprod;

  logic [D_W-1:0]          d_even;
  logic [D_W-1:0]          d_odd;
  logic [PROD_W:0]         rounded;
  logic [MAG_W-1:0]        p;
  logic [NUM_W-1:0]        q_est;
  logic [NUM_W:0]          rem;
  logic [NUM_W-1:0]        q;
  logic [MAG_W-1:0]        a_k;
  logic                    active;
  logic signed [SUM_W-1:0] term;
  logic signed [SUM_W-1:0] sum_next;

  assign d_even  = {k_index, 1'b0};
  assign d_odd   = d_even - D_W'(1);
  assign rounded = (PROD_W+1)'(s1_prod) + (PROD_W+1)'(1 << (F - 1));
  assign p       = MAG_W'(rounded >> F);

  // reciprocal estimate is low by at most one
  assign q_est = NUM_W'(s3_qprod >> NUM_W);
  assign rem   = (NUM_W+1)'(s3_num) - (NUM_W+1)'(q_est * NUM_W'(d_even));
  assign q     = (rem >= (NUM_W+1)'(d_even)) ? q_est + NUM_W'(1) : q_est;
  assign a_k   = MAG_W'(q);

  assign active   = N_W'(k_index) < s3_n;
  assign term     = $signed(SUM_W'(a_k));
  assign sum_next = !active ? s3_sum :
                    (s3_neg && k_index[0]) ? s3_sum - term : s3_sum + term;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      s2_valid   <= 1'b0;
      s3_valid   <= 1'b0;
      down.valid <= 1'b0;
    end else if (en) begin
      s1_valid   <= up.valid;
      s2_valid   <= s1_valid;
      s3_valid   <= s2_valid;
      down.valid <= s3_valid;
    end
    if (en) begin
      s1_prod  <= PROD_W'(up.a) * PROD_W'(up.m);
      s1_m     <= up.m;
      s1_neg   <= up.neg;
      s1_sum   <= up.sum;
      s1_n     <= up.n;

      s2_num   <= NUM_W'(p) * NUM_W'(d_odd) + NUM_W'(k_index);
      s2_m     <= s1_m;
      s2_neg   <= s1_neg;
      s2_sum   <= s1_sum;
      s2_n     <= s1_n;

      s3_qprod <= QPROD_W'(s2_num) * QPROD_W'(recip);
      s3_num   <= s2_num;
      s3_m     <= s2_m;
      s3_neg   <= s2_neg;
      s3_sum   <= s2_sum;
      s3_n     <= s2_n;

      down.a   <= a_k;
      down.m   <= s3_m;
      down.neg <= s3_neg;
      down.sum <= sum_next;
      down.n   <= s3_n;
    end
  end

endmodule

[rtl/bsis_out_stage.sv]
// ---------------------------------------------------------------------------
// bsis_out_stage: saturation and output register with skid
// clips the sum to the result range and decouples the receiver
// ---------------------------------------------------------------------------
module bsis_out_stage (
  input  logic                 clk,
  input  logic                 rst,
  input  bsis_pkg::cell_data_t tail,
  output logic                 en,
  bsis_out_if.source           series_out
);

  localparam int SUM_W = bsis_pkg::SUM_W;
  localparam int OUT_W = bsis_pkg::OUT_W;

  localparam logic signed [SUM_W-1:0] SAT_HI =
    {{(SUM_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SAT_LO =
    {{(SUM_W-OUT_W+1){1'b1}}, {(OUT_W-1){1'b0}}};

  logic signed [OUT_W-1:0] clip_value;
  logic                    clip_flag;
  logic                    skid_full;
  logic signed [OUT_W-1:0] skid_value;
  logic                    skid_flag;

  always_comb begin
    priority if (tail.sum > SAT_HI) begin
      clip_value = OUT_W'(SAT_HI);
      clip_flag  = 1'b1;
    end else if (tail.sum < SAT_LO) begin
      clip_value = OUT_W'(SAT_LO);
      clip_flag  = 1'b1;
    end else begin
      clip_value = OUT_W'(tail.sum);
      clip_flag  = 1'b0;
    end
  end

  assign en = !skid_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      series_out.valid <= 1'b0;
      skid_full        <= 1'b0;
    end else if (!series_out.valid || series_out.ready) begin
      series_out.valid <= skid_full || tail.valid;
      skid_full        <= 1'b0;
    end else if (tail.valid && !skid_full) begin
      skid_full <= 1'b1;
    end
    if (!series_out.valid || series_out.ready) begin
      series_out.series_value <= skid_full ? skid_value : clip_value;
      series_out.saturated    <= skid_full ? skid_flag : clip_flag;
    end else if (tail.valid && !skid_full) begin
      skid_value <= clip_value;
      skid_flag  <= clip_flag;
    end
  end

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_full |-> series_out.valid)
    else $error("skid holds a result while the output register is empty");

  a_skid_holds: assert property (@(posedge clk) disable iff (rst)
    skid_full && !series_out.ready |=> skid_full)
    else $error("skid result dropped during a stall");

  a_skid_catch: assert property (@(posedge clk) disable iff (rst)
    en && tail.valid && series_out.valid && !series_out.ready |=> skid_full)
    else $error("pipeline result lost while output stalled");

  a_sat_limit: assert property (@(posedge clk) disable iff (rst)
    series_out.valid && series_out.saturated |->
      (series_out.series_value == OUT_W'(SAT_HI) ||
       series_out.series_value == OUT_W'(SAT_LO)))
    else $error("saturated flag set on an unclipped value");

endmodule

[rtl/binomial_series_inv_sqrt_unit.sv]
// ---------------------------------------------------------------------------
// binomial_series_inv_sqrt_unit: truncated series of 1/sqrt(1+x)
// Evaluates 1 + sum c_k * (-x)^k term by term in a chain of cells.
//
// x_in carries x (signed, FRAC_BITS fraction bits, in [-1,1)); series_out
// returns the clipped sum (signed Q3.FRAC_BITS) and a saturation flag.
// A transfer happens on a channel when valid and ready are both high.
// cfg_write_en/cfg_write_data write term_count (terms including the 1);
// zero acts as one term, values above MAX_TERMS act as MAX_TERMS.
// Write it only while no item is in flight.
//
// Pipeline: one entry register, four stages per cell for MAX_TERMS-1
// cells, one output register. Throughput is one item per cycle while
// x_in.ready is high, set by the fully pipelined cell chain.
// Reset clears all valid bits and loads term_count with 8.
// When the receiver stalls, one result waits in the output register and
// one more is caught in a skid register; the pipeline then freezes and
// x_in.ready drops until the skid drains.
// ---------------------------------------------------------------------------
module binomial_series_inv_sqrt_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write_en,
  input  logic [bsis_pkg::CNT_W-1:0]     cfg_write_data,
  bsis_in_if.sink                        x_in,
  bsis_out_if.source                     series_out
);

  localparam int MAX_TERMS = bsis_pkg::MAX_TERMS;
  localparam int X_W       = bsis_pkg::X_W;
  localparam int MAG_W     = bsis_pkg::MAG_W;
  localparam int N_W       = bsis_pkg::N_W;
  localparam int K_W       = bsis_pkg::K_W;
  localparam int NUM_W     = bsis_pkg::NUM_W;
  localparam int SUM_W     = bsis_pkg::SUM_W;
  localparam int CNT_W     = bsis_pkg::CNT_W;
  localparam int F         = bsis_pkg::FRAC_BITS;

  logic [CNT_W-1:0]      term_count;
  logic                  en;
  logic [CNT_W:0]        count_wide;
  logic [N_W-1:0]        n_eff;
  logic signed [X_W:0]   x_ext;
  logic signed [X_W:0]   x_abs;

  // chain[0] is the entry register, chain[k] leaves cell k
  bsis_pkg::cell_data_t chain [MAX_TERMS];

  // term count register
  always_ff @(posedge clk) begin
    if (rst) begin
      term_count <= bsis_pkg::TERM_RESET;
    end else if (cfg_write_en) begin
      term_count <= cfg_write_data;
    end
  end

  // clamp the count into 1..MAX_TERMS
  assign count_wide = (CNT_W+1)'(term_count);
  always_comb begin
    priority if (count_wide == '0) begin
      n_eff = N_W'(1);
    end else if (count_wide > (CNT_W+1)'(MAX_TERMS)) begin
      n_eff = N_W'(MAX_TERMS);
    end else begin
      n_eff = N_W'(count_wide);
    end
  end

  // u = -x: magnitude |x|, terms alternate in sign when x is positive
  assign x_ext = (X_W+1)'(x_in.x_value);
  assign x_abs = x_ext[X_W] ? -x_ext : x_ext;

  assign x_in.ready = en;

  // entry register: term zero is the constant 1.0
  always_ff @(posedge clk) begin
    if (rst) begin
      chain[0].valid <= 1'b0;
    end else if (en) begin
      chain[0].valid <= x_in.valid;
    end
    if (en) begin
      chain[0].a   <= MAG_W'(1) << F;
      chain[0].m   <= MAG_W'(x_abs);
      chain[0].neg <= !x_ext[X_W] && (x_ext != '0);
      chain[0].sum <= SUM_W'(1) << F;
      chain[0].n   <= n_eff;
    end
  end

  // one cell per term k, reciprocal of 2k worked out at elaboration
  for (genvar k = 1; k < MAX_TERMS; k++) begin : g_cell
    localparam logic [NUM_W-1:0] RECIP = NUM_W'((64'd1 << NUM_W) / 64'(2 * k));

    bsis_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .k_index (K_W'(k)),
      .recip   (RECIP),
      .up      (chain[k-1]),
      .down    (chain[k])
    );
  end

  // clip, output register and skid
  bsis_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .tail       (chain[MAX_TERMS-1]),
    .en         (en),
    .series_out (series_out)
  );

endmodule
